// File: sv/u8dec_pkg.sv
// shared types and constants for the utf-8 code point decoder
// no dependencies; used by the interfaces, the decode core and the top level

package u8dec_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned CpW   = 21;
  localparam int unsigned PendW = 2;

  localparam logic [CpW-1:0]   SubstituteChar = 21'h00003F;
  localparam logic [PendW-1:0] PendNone       = 2'd0;
  localparam logic [PendW-1:0] PendOne        = 2'd1;
  localparam logic [PendW-1:0] PendTwo        = 2'd2;
  localparam logic [PendW-1:0] PendThree      = 2'd3;

  // lead byte patterns and their payload masks
  localparam logic [ByteW-1:0] Lead2Mask  = 8'hE0;
  localparam logic [ByteW-1:0] Lead2Code  = 8'hC0;
  localparam logic [ByteW-1:0] Lead3Mask  = 8'hF0;
  localparam logic [ByteW-1:0] Lead3Code  = 8'hE0;
  localparam logic [ByteW-1:0] Lead4Mask  = 8'hF8;
  localparam logic [ByteW-1:0] Lead4Code  = 8'hF0;
  localparam logic [ByteW-1:0] Lead2Bits  = 8'h1F;
  localparam logic [ByteW-1:0] Lead3Bits  = 8'h0F;
  localparam logic [ByteW-1:0] Lead4Bits  = 8'h07;
  localparam logic [ByteW-1:0] ContBits   = 8'h3F;

  // result of decoding one byte against the current state
  typedef struct packed {
    logic           emit;
    logic           is_substitute;
    logic [CpW-1:0] code_point;
  } dec_t;

endpackage

// File: sv/u8dec_in_if.sv
// byte channel into the decoder: valid/ready plus one stream byte
// depends on u8dec_pkg

interface u8dec_in_if;
  logic                         valid;
  logic                         ready;
  logic [u8dec_pkg::ByteW-1:0]  in_byte;
  logic                         end_of_stream;

  modport source (output valid, output in_byte, output end_of_stream, input ready);
  modport sink   (input valid, input in_byte, input end_of_stream, output ready);
endinterface

// File: sv/u8dec_out_if.sv
// code point channel out of the decoder: valid/ready plus one result
// depends on u8dec_pkg

interface u8dec_out_if;
  logic                       valid;
  logic                       ready;
  logic [u8dec_pkg::CpW-1:0]  code_point;
  logic                       is_substitute;

  modport source (output valid, output code_point, output is_substitute, input ready);
  modport sink   (input valid, input code_point, input is_substitute, output ready);
endinterface

// File: sv/u8dec_core.sv
// decode core: pending-byte count and partial code point, one byte per fire
// depends on u8dec_pkg

module u8dec_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          fire_i,
  input  logic [u8dec_pkg::ByteW-1:0]   byte_i,
  input  logic                          eos_i,
  output u8dec_pkg::dec_t               dec_o,
  output logic [u8dec_pkg::PendW-1:0]   pend_o
);

  logic [u8dec_pkg::PendW-1:0] pend_q, pend_d;
  logic [u8dec_pkg::CpW-1:0]   part_q, part_d;
  logic [u8dec_pkg::CpW-1:0]   merged;
  logic [u8dec_pkg::PendW-1:0] pend_dec;

  assign merged   = {part_q[u8dec_pkg::CpW-7:0], byte_i[5:0]};
  assign pend_dec = pend_q - u8dec_pkg::PendOne;

  always_comb begin
    dec_o  = '0;
    pend_d = pend_q;
    part_d = part_q;
    if (pend_q != u8dec_pkg::PendNone) begin
      // every byte here counts as a continuation, no check
      pend_d = pend_dec;
      part_d = merged;
      if (pend_dec == u8dec_pkg::PendNone) begin
        dec_o.emit       = 1'b1;
        dec_o.code_point = merged;
        part_d           = '0;
      end else if (eos_i) begin
        pend_d = u8dec_pkg::PendNone;
        part_d = '0;
      end
    end else if (!byte_i[7]) begin
      dec_o.emit       = 1'b1;
      dec_o.code_point = {{(u8dec_pkg::CpW-u8dec_pkg::ByteW){1'b0}}, byte_i};
    end else if ((byte_i & u8dec_pkg::Lead2Mask) == u8dec_pkg::Lead2Code) begin
      pend_d = u8dec_pkg::PendOne;
      part_d = {{(u8dec_pkg::CpW-u8dec_pkg::ByteW){1'b0}}, byte_i & u8dec_pkg::Lead2Bits};
    end else if ((byte_i & u8dec_pkg::Lead3Mask) == u8dec_pkg::Lead3Code) begin
      pend_d = u8dec_pkg::PendTwo;
      part_d = {{(u8dec_pkg::CpW-u8dec_pkg::ByteW){1'b0}}, byte_i & u8dec_pkg::Lead3Bits};
    end else if ((byte_i & u8dec_pkg::Lead4Mask) == u8dec_pkg::Lead4Code) begin
      pend_d = u8dec_pkg::PendThree;
      part_d = {{(u8dec_pkg::CpW-u8dec_pkg::ByteW){1'b0}}, byte_i & u8dec_pkg::Lead4Bits};
    end else begin
      dec_o.emit          = 1'b1;
      dec_o.is_substitute = 1'b1;
      dec_o.code_point    = u8dec_pkg::SubstituteChar;
    end
    // a lead byte that ends the stream is dropped
    if (pend_q == u8dec_pkg::PendNone && eos_i) begin
      pend_d = u8dec_pkg::PendNone;
      part_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= u8dec_pkg::PendNone;
      part_q <= '0;
    end else if (fire_i) begin
      pend_q <= pend_d;
      part_q <= part_d;
    end
  end

  assign pend_o = pend_q;

endmodule

// File: sv/utf8_code_point_decoder.sv
// Accepts one UTF-8 byte per cycle, back to back, while no finished result
// waits on a stalled sink, and returns one code point per complete 1- to
// 4-byte sequence. The result is registered: the byte passes an input
// register, is decoded in a single pass against the pending-byte count and
// partial value, and lands in a result register that holds while the sink
// stalls. Bytes that finish no code point leave nothing on the output; a
// sequence cut short by end_of_stream is dropped and the decoder starts
// fresh on the next byte. Stray continuation bytes and leads of 0xF8..0xFF
// come out as '?' (0x3F) with is_substitute set.

module utf8_code_point_decoder (
  input  logic  clk_i,
  input  logic  rst_ni,
  u8dec_in_if.sink     in_i,
  u8dec_out_if.source  out_o
);

  logic                        s1_valid_q;
  logic [u8dec_pkg::ByteW-1:0] s1_byte_q;
  logic                        s1_eos_q;
  logic                        s1_fire;
  logic                        out_free;
  logic                        out_valid_q;
  logic [u8dec_pkg::CpW-1:0]   out_cp_q;
  logic                        out_sub_q;
  u8dec_pkg::dec_t             dec;
  logic [u8dec_pkg::PendW-1:0] pend;

  u8dec_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (s1_fire),
    .byte_i (s1_byte_q),
    .eos_i  (s1_eos_q),
    .dec_o  (dec),
    .pend_o (pend)
  );

  assign out_free = !out_valid_q || out_o.ready;
  // a byte that makes no result never waits on the output side
  assign s1_fire  = s1_valid_q && (out_free || !dec.emit);
  assign in_i.ready = !s1_valid_q || s1_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      s1_byte_q <= in_i.in_byte;
      s1_eos_q  <= in_i.end_of_stream;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_fire && dec.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && dec.emit) begin
      out_cp_q  <= dec.code_point;
      out_sub_q <= dec.is_substitute;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.code_point    = out_cp_q;
  assign out_o.is_substitute = out_sub_q;

`ifndef ASSERT_OFF
  a_sub_is_qmark : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_sub_q |-> out_cp_q == u8dec_pkg::SubstituteChar)
    else $error("substitute result without 0x3f");

  a_eos_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire && s1_eos_q |=> pend == u8dec_pkg::PendNone)
    else $error("state not cleared after end of stream");

  a_emit_lands : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire && dec.emit |=> out_valid_q)
    else $error("decoded result lost");
`endif

endmodule
